// ===== rtl/qmmf_pkg.sv =====
package qmmf_pkg;

   localparam logic [7:0] PIX_MAX = 8'hFF;

   localparam logic [2:0]  FILTER_SIZE_RESET  = 3'd2;
   localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd480;

   typedef enum logic [1:0] {
      CSR_FILTER_SIZE  = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // minima of one window column over the lower and upper row spans
   typedef struct packed {
      logic [7:0] lo;
      logic [7:0] hi;
   } colmin_type;

   // one column's share of each quadrant, PIX_MAX where it lies outside
   typedef struct packed {
      logic [7:0] tl;
      logic [7:0] tr;
      logic [7:0] bl;
      logic [7:0] br;
   } quad_type;

   function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== rtl/qmmf_line_store.sv =====
module qmmf_line_store
   import qmmf_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int SD    = 6
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [SD-1:0][7:0]    rd_data,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [7:0]            wr_pixel
);

   // each entry holds the column history, newest line first
   logic [SD-1:0][7:0] mem [DEPTH];
   logic [SD-1:0][7:0] rd_data_ff;
   logic [SD-1:0][7:0] wr_stack;

   always_comb begin
      wr_stack[0] = wr_pixel;
      for (int k = 1; k < SD; k++) begin
         wr_stack[k] = rd_data_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_stack;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/qmmf_cell.sv =====
module qmmf_cell
   import qmmf_pkg::*;
#(
   parameter int CELL_IDX = 0,
   parameter int BW       = 2
) (
   input  logic           clock,
   input  logic           shift,
   input  logic [BW-1:0]  b,
   input  colmin_type     col_in,
   output colmin_type     col_out,
   output quad_type       quad
);

   localparam logic [BW+1:0] D = (BW+2)'(CELL_IDX);

   colmin_type col_ff;
   logic       right_side;
   logic       left_side;

   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      right_side = D <= {2'b00, b};
      left_side  = (D >= {2'b00, b}) && (D <= {1'b0, b, 1'b0});
      quad.br = right_side ? col_ff.lo : PIX_MAX;
      quad.tr = right_side ? col_ff.hi : PIX_MAX;
      quad.bl = left_side  ? col_ff.lo : PIX_MAX;
      quad.tl = left_side  ? col_ff.hi : PIX_MAX;
   end

   assign col_out = col_ff;

endmodule

// ===== rtl/quadrant_maxmin_filter_unit.sv =====
// channel   | handshake             | payload
// req       | req_valid / req_stall | req_pixel, req_frame_start
// rsp       | rsp_valid / rsp_stall | rsp_out_x, rsp_out_y, rsp_value
// csr       | csr_we (no wait)      | csr_index, csr_wdata
// one pixel per cycle while no result stalls; a result passes the line store
// read, column cells, quadrant minima and output register after its lower-right
// window pixel is taken. the line store port and the column cell chain set the
// rate. reset clears counters, valids and csr registers, not the line store or
// data registers. a stalled result holds the whole pipeline and raises req_stall.
module quadrant_maxmin_filter_unit
   import qmmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_FILTER = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_pixel,
   input  logic         req_frame_start,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [9:0]   rsp_out_x,
   output logic [9:0]   rsp_out_y,
   output logic [7:0]   rsp_value,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [10:0]  csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int DW = (XW + 1 > 11) ? XW + 1 : 11;
   localparam int BW = (MAX_FILTER > 1) ? $clog2(MAX_FILTER) : 1;
   localparam int NR = 2 * MAX_FILTER - 1;
   localparam int SD = (MAX_FILTER > 1) ? NR - 1 : 1;

   logic [2:0]  filter_size_ff;
   logic [10:0] frame_width_ff;
   logic [10:0] frame_height_ff;

   logic [XW-1:0] col_ff, col_in;
   logic [XW-1:0] row_ff, row_in;

   logic          en;
   logic          accept;
   logic [DW-1:0] w, h;
   logic [3:0]    fs;
   logic [BW-1:0] b;
   logic [XW-1:0] x_cur, y_cur;
   logic          emit;

   logic          s0_valid_ff;
   logic          s0_emit_ff;
   logic [7:0]    s0_pix_ff;
   logic [XW-1:0] s0_x_ff, s0_y_ff;
   logic [SD-1:0][7:0] stack;
   colmin_type    s0_col;

   logic          s1_valid_ff;
   logic [XW-1:0] s1_x_ff, s1_y_ff;
   colmin_type    cell_col [NR];
   quad_type      cell_quad [NR];
   quad_type      qmin;

   logic          s2_valid_ff;
   logic [XW-1:0] s2_x_ff, s2_y_ff;
   quad_type      s2_quad_ff;

   logic          rsp_valid_ff;
   logic [9:0]    rsp_x_ff, rsp_y_ff;
   logic [7:0]    rsp_value_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // effective geometry
   always_comb begin
      w = ((frame_width_ff == 11'd0) || (DW'(frame_width_ff) > DW'(MAX_WIDTH)))
          ? DW'(MAX_WIDTH) : DW'(frame_width_ff);
      h = ((frame_height_ff == 11'd0) || (DW'(frame_height_ff) > DW'(MAX_WIDTH)))
          ? DW'(MAX_WIDTH) : DW'(frame_height_ff);
      if (filter_size_ff == 3'd0) begin
         fs = 4'd1;
      end else if (4'(filter_size_ff) > 4'(MAX_FILTER)) begin
         fs = 4'(MAX_FILTER);
      end else begin
         fs = 4'(filter_size_ff);
      end
      b = BW'(fs - 4'd1);
   end

   // position of the incoming pixel and counter advance
   always_comb begin
      x_cur = req_frame_start ? '0 : col_ff;
      y_cur = req_frame_start ? '0 : row_ff;
      emit  = (DW'(x_cur) < w) && (DW'(y_cur) < h)
              && (DW'(x_cur) >= DW'({b, 1'b0})) && (DW'(y_cur) >= DW'({b, 1'b0}));
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (DW'(x_cur) + DW'(1) >= w) begin
            col_in = '0;
            row_in = (DW'(y_cur) + DW'(1) >= h) ? '0 : y_cur + XW'(1);
         end else begin
            col_in = x_cur + XW'(1);
            row_in = y_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_size_ff  <= FILTER_SIZE_RESET;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_SIZE:  filter_size_ff  <= csr_wdata[2:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (en) begin
            s0_valid_ff  <= req_valid;
            s1_valid_ff  <= s0_valid_ff && s0_emit_ff;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_pix_ff  <= req_pixel;
         s0_x_ff    <= x_cur;
         s0_y_ff    <= y_cur;
         s0_emit_ff <= emit;
      end
      if (en) begin
         s1_x_ff    <= s0_x_ff;
         s1_y_ff    <= s0_y_ff;
         s2_x_ff    <= s1_x_ff - XW'(b);
         s2_y_ff    <= s1_y_ff - XW'(b);
         s2_quad_ff <= qmin;
         rsp_x_ff   <= 10'(s2_x_ff);
         rsp_y_ff   <= 10'(s2_y_ff);
         rsp_value_ff <= max8(max8(s2_quad_ff.tl, s2_quad_ff.tr),
                              max8(s2_quad_ff.bl, s2_quad_ff.br));
      end
   end

   qmmf_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (XW),
      .SD    (SD)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (x_cur),
      .rd_data  (stack),
      .wr_en    (en && s0_valid_ff),
      .wr_addr  (s0_x_ff),
      .wr_pixel (s0_pix_ff)
   );

   // column minima over rows y-b..y and y-2b..y-b
   always_comb begin
      s0_col.lo = s0_pix_ff;
      s0_col.hi = (b == '0) ? s0_pix_ff : PIX_MAX;
      for (int r = 1; r < NR; r++) begin
         if ((BW+2)'(r) <= {2'b00, b}) begin
            s0_col.lo = min8(s0_col.lo, stack[r-1]);
         end
         if (((BW+2)'(r) >= {2'b00, b}) && ((BW+2)'(r) <= {1'b0, b, 1'b0})) begin
            s0_col.hi = min8(s0_col.hi, stack[r-1]);
         end
      end
   end

   for (genvar k = 0; k < NR; k++) begin : g_cell
      qmmf_cell #(
         .CELL_IDX (k),
         .BW       (BW)
      ) u_cell (
         .clock   (clock),
         .shift   (en && s0_valid_ff),
         .b       (b),
         .col_in  ((k == 0) ? s0_col : cell_col[(k == 0) ? 0 : k-1]),
         .col_out (cell_col[k]),
         .quad    (cell_quad[k])
      );
   end

   always_comb begin
      qmin = '{tl: PIX_MAX, tr: PIX_MAX, bl: PIX_MAX, br: PIX_MAX};
      for (int k = 0; k < NR; k++) begin
         qmin.tl = min8(qmin.tl, cell_quad[k].tl);
         qmin.tr = min8(qmin.tr, cell_quad[k].tr);
         qmin.bl = min8(qmin.bl, cell_quad[k].bl);
         qmin.br = min8(qmin.br, cell_quad[k].br);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ===== sim/quadrant_maxmin_filter_checker.sv =====
module quadrant_maxmin_filter_checker
   import qmmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_out_x,
   input  logic [9:0]  rsp_out_y,
   input  logic [7:0]  rsp_value,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_LINES = 7;
   localparam int LINE_PIXELS = 1024;

   typedef struct {
      logic [9:0] x;
      logic [9:0] y;
      logic [7:0] value;
   } filtered_pixel_type;

   filtered_pixel_type expected_pixels[$];
   logic [7:0] line_mem [0:STORE_LINES-1][0:LINE_PIXELS-1];
   logic [2:0]  size_reg;
   logic [10:0] width_reg;
   logic [10:0] height_reg;
   int col_pos;
   int row_pos;

   function automatic int clamp_dim(logic [10:0] v);
      return (v == 0 || v > LINE_PIXELS) ? LINE_PIXELS : int'(v);
   endfunction

   // store the pixel, queue a result when it completes an interior window
   function automatic void take_pixel(logic [7:0] pix, logic fstart);
      int w, h, side, b, x, y, cx, cy, sy;
      logic [7:0] best, m, v;
      filtered_pixel_type fp;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      side = (size_reg == 0) ? 1 : (size_reg > 4) ? 4 : int'(size_reg);
      b = side - 1;
      if (fstart) begin
         col_pos = 0;
         row_pos = 0;
      end
      x = col_pos;
      y = row_pos;
      line_mem[y % STORE_LINES][x] = pix;
      if (x < w && y < h && x >= 2 * b && y >= 2 * b) begin
         cx = x - b;
         cy = y - b;
         best = 8'd0;
         for (int qy = 0; qy < 2; qy++)
            for (int qx = 0; qx < 2; qx++) begin
               m = PIX_MAX;
               for (int j = 0; j < side; j++) begin
                  sy = (cy - b + qy * b + j) % STORE_LINES;
                  for (int i = 0; i < side; i++) begin
                     v = line_mem[sy][cx - b + qx * b + i];
                     if (v < m) m = v;
                  end
               end
               if (m > best) best = m;
            end
         fp.x = cx[9:0];
         fp.y = cy[9:0];
         fp.value = best;
         expected_pixels = {expected_pixels, fp};
      end
      col_pos = x + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type fp;
      if (reset) begin
         size_reg <= FILTER_SIZE_RESET;
         width_reg <= FRAME_WIDTH_RESET;
         height_reg <= FRAME_HEIGHT_RESET;
         col_pos = 0;
         row_pos = 0;
         error_count = 0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FILTER_SIZE:  size_reg <= csr_wdata[2:0];
               CSR_FRAME_WIDTH:  width_reg <= csr_wdata;
               CSR_FRAME_HEIGHT: height_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result x=%0d y=%0d value=%0d",
                      rsp_out_x, rsp_out_y, rsp_value);
               error_count++;
            end else begin
               fp = expected_pixels.pop_front();
               if (rsp_out_x !== fp.x) begin
                  $error("out_x expected %0d got %0d", fp.x, rsp_out_x);
                  error_count++;
               end
               if (rsp_out_y !== fp.y) begin
                  $error("out_y expected %0d got %0d", fp.y, rsp_out_y);
                  error_count++;
               end
               if (rsp_value !== fp.value) begin
                  $error("value expected %0d got %0d", fp.value, rsp_value);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) take_pixel(req_pixel, req_frame_start);
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ===== sim/quadrant_maxmin_filter_unit_tb.sv =====
module quadrant_maxmin_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qmmf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_pixel;
   logic        req_frame_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [9:0]  rsp_out_x;
   logic [9:0]  rsp_out_y;
   logic [7:0]  rsp_value;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;
   int          error_count;
   int          pending_count;
   int          cycle_count;
   int          send_idle_pct;
   int          stall_pct;

   quadrant_maxmin_filter_unit dut (.*);

   quadrant_maxmin_filter_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // pick one of the idling patterns: none, sender, receiver, both
   task automatic pick_idling();
      case ($urandom_range(3))
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 82; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 82; end
         default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
   endtask

   task automatic send_request(logic [7:0] pix, logic fstart);
      req_valid <= 1'b1;
      req_pixel <= pix;
      req_frame_start <= fstart;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic write_setup(logic [10:0] fsize, logic [10:0] w, logic [10:0] h);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FILTER_SIZE;
      csr_wdata <= fsize;
      @(posedge clock);
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly whole frames with random content, a few early frame restarts
   task automatic run_frames(logic [10:0] fsize, logic [10:0] w, logic [10:0] h,
                             int count);
      int frame_len, pos;
      logic fstart;
      logic [7:0] pix;
      frame_len = ((w == 0 || w > 1024) ? 1024 : w) * ((h == 0 || h > 1024) ? 1024 : h);
      write_setup(fsize, w, h);
      pos = 0;
      for (int n = 0; n < count; n++) begin
         fstart = (pos == 0) || ($urandom_range(99) < 1);
         if (fstart) pos = 0;
         if (pos == 0 && $urandom_range(3) == 0) pick_idling();
         case ($urandom_range(9))
            0: pix = PIX_MAX;
            1: pix = 8'd0;
            2, 3: pix = 8'd120 + 8'($urandom_range(15));
            default: pix = 8'($urandom_range(255));
         endcase
         send_request(pix, fstart);
         pos = (pos + 1 == frame_len) ? 0 : pos + 1;
      end
   endtask

   initial begin
      logic [7:0] directed_pixels [16];
      directed_pixels = '{8'd0, 8'hFF, 8'd1, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA,
                          8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h01, 8'h02, 8'h04, 8'h08};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel <= '0;
      req_frame_start <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_FILTER_SIZE;
      csr_wdata <= '0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size zero acts as one: each pixel comes back as is
      write_setup(11'd0, 11'd5, 11'd3);
      for (int i = 0; i < 16; i++) send_request(directed_pixels[i], i == 0);
      send_request(8'h99, 1'b1);
      send_request(8'h66, 1'b0);
      // oversized filter saturates to four
      write_setup(11'd7, 11'd7, 11'd7);
      for (int i = 0; i < 49; i++) send_request(8'($urandom_range(255)), i == 0);

      run_frames(11'd1, 11'd16, 11'd8, 100);
      run_frames(11'd2, 11'd9, 11'd7, 100);
      run_frames(11'd3, 11'd12, 11'd10, 130);
      run_frames(11'd4, 11'd10, 11'd9, 100);
      run_frames(11'd5, 11'd8, 11'd8, 70);
      run_frames(11'd2, 11'd5, 11'd0, 40);
      // widest line with a wrapping row, then tallest frame one pixel wide
      run_frames(11'd0, 11'h7FF, 11'd1, 1030);
      run_frames(11'd1, 11'd1, 11'd1024, 30);

      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/qmmf_pkg.sv
rtl/qmmf_line_store.sv
rtl/qmmf_cell.sv
rtl/quadrant_maxmin_filter_unit.sv
sim/quadrant_maxmin_filter_checker.sv
sim/quadrant_maxmin_filter_unit_tb.sv
